// ===== hdl/mde_pkg.sv =====
// Shared types and constants for the modular division block.
// Holds the sequencer state encoding, divider command/status structs and CSR layout.
// No dependencies.
package mde_pkg;

   localparam int unsigned INPUT_WIDTH    = 63;
   localparam int unsigned QUOTIENT_WIDTH = 32;
   localparam int unsigned DIV_WIDTH      = 64;
   localparam int unsigned STEP_WIDTH     = 7;
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [31:0] MODULUS_RESET = 32'd1000000007;
   localparam logic        REG_MODULUS   = 1'b0;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_RED_A   = 9'b000000010,
      S_RED_B   = 9'b000000100,
      S_EUC_CHK = 9'b000001000,
      S_EUC_DIV = 9'b000010000,
      S_MUL     = 9'b000100000,
      S_PSTART  = 9'b001000000,
      S_RED_P   = 9'b010000000,
      S_OUT     = 9'b100000000
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [STEP_WIDTH-1:0] steps;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

// ===== hdl/mde_req_if.sv =====
// Request channel of the modular division block: dividend and divisor.
// Depends on mde_pkg for field widths.
interface mde_req_if;
   logic                               valid;
   logic                               ready;
   logic [mde_pkg::INPUT_WIDTH-1:0]    dividend;
   logic [mde_pkg::INPUT_WIDTH-1:0]    divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

// ===== hdl/mde_rsp_if.sv =====
// Response channel of the modular division block: quotient and no-inverse flag.
// Depends on mde_pkg for field widths.
interface mde_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [mde_pkg::QUOTIENT_WIDTH-1:0]  quotient;
   logic                                no_inverse;

   modport source (output valid, output quotient, output no_inverse, input ready);
   modport sink   (input valid, input quotient, input no_inverse, output ready);
endinterface

// ===== hdl/mde_div_unit.sv =====
// Shared restoring divider: one quotient bit per cycle over a left-aligned dividend.
// Also accumulates quotient times a multiplicand for the Bezout update.
// Depends on mde_pkg.
module mde_div_unit #(
   parameter int unsigned MODULUS_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mde_pkg::div_cmd_type               cmd,
   input  logic [mde_pkg::DIV_WIDTH-1:0]      dividend,
   input  logic [MODULUS_WIDTH-1:0]           divisor,
   input  logic [MODULUS_WIDTH-1:0]           mult,
   output mde_pkg::div_sts_type               sts,
   output logic [MODULUS_WIDTH-1:0]           remainder,
   output logic [MODULUS_WIDTH-1:0]           acc
);

   localparam int unsigned W  = MODULUS_WIDTH;
   localparam int unsigned DW = mde_pkg::DIV_WIDTH;
   localparam int unsigned SW = mde_pkg::STEP_WIDTH;

   logic [DW-1:0] dvd_ff, dvd_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  div_ff, div_in;
   logic [W-1:0]  mult_ff, mult_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [W:0]    rem_sh;
   logic [W:0]    rem_sub;
   logic          ge;

   assign rem_sh  = {rem_ff, dvd_ff[DW-1]};
   assign ge      = rem_sh >= {1'b0, div_ff};
   assign rem_sub = rem_sh - {1'b0, div_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      div_in  = div_ff;
      mult_in = mult_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         acc_in  = '0;
         div_in  = divisor;
         mult_in = mult;
         cnt_in  = cmd.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         rem_in = ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
         acc_in = (acc_ff << 1) + (ge ? mult_ff : '0);
         cnt_in = cnt_ff - SW'(1);
         if (cnt_ff == SW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      acc_ff  <= acc_in;
      div_ff  <= div_in;
      mult_ff <= mult_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign remainder = rem_ff;
   assign acc       = acc_ff;

endmodule

// ===== hdl/modular_division_ext_euclid.sv =====
// Top level of the modular division block: sequencer, modulus register and APB port.
// Depends on mde_pkg, mde_req_if, mde_rsp_if and mde_div_unit.
//
// Computes dividend / divisor modulo the configured modulus (register 0 at byte
// address 0, reset value 1000000007), raising no_inverse with a quotient of 0 when the
// divisor shares a factor with the modulus or the modulus is 0. One request is
// worked at a time; a new request is taken only after the previous response leaves.
// Reductions and Euclid divisions run through one restoring divider that yields one
// bit per cycle: it reduces the dividend and the divisor, divides in every extended
// Euclid round and reduces the final product, which a multiplier forms from the
// reduced dividend and the inverse. A zero modulus answers without the divider.
module modular_division_ext_euclid #(
   parameter int unsigned MODULUS_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   mde_req_if.sink                               req_ch,
   mde_rsp_if.source                             rsp_ch,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [mde_pkg::CSR_ADDR_WIDTH-1:0]    paddr,
   input  logic [mde_pkg::CSR_DATA_WIDTH-1:0]    pwdata,
   output logic [mde_pkg::CSR_DATA_WIDTH-1:0]    prdata,
   output logic                                  pready
);

   localparam int unsigned W  = MODULUS_WIDTH;
   localparam int unsigned PW = 2 * MODULUS_WIDTH;
   localparam int unsigned DW = mde_pkg::DIV_WIDTH;
   localparam int unsigned SW = mde_pkg::STEP_WIDTH;
   localparam int unsigned IW = mde_pkg::INPUT_WIDTH;
   localparam int unsigned QW = mde_pkg::QUOTIENT_WIDTH;
   localparam int unsigned CW = mde_pkg::CSR_DATA_WIDTH;

   localparam logic [SW-1:0] STEPS_INPUT = SW'(DW);
   localparam logic [SW-1:0] STEPS_EUC   = SW'(W);
   localparam logic [SW-1:0] STEPS_PROD  = SW'(PW);
   localparam logic [W-1:0]  MOD_RESET   = W'(mde_pkg::MODULUS_RESET);
   localparam logic [W-1:0]  ONE         = W'(1);

   mde_pkg::state_type   state_ff, state_in;
   logic [W-1:0]         mod_ff, mod_in;
   logic [IW-1:0]        b_ff, b_in;
   logic [W-1:0]         a_red_ff, a_red_in;
   logic [W-1:0]         r_prev_ff, r_prev_in;
   logic [W-1:0]         r_cur_ff, r_cur_in;
   logic [W-1:0]         u_prev_ff, u_prev_in;
   logic [W-1:0]         u_cur_ff, u_cur_in;
   logic                 neg_cur_ff, neg_cur_in;
   logic [W-1:0]         inv_ff, inv_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic [W-1:0]         quot_ff, quot_in;
   logic                 flag_ff, flag_in;

   mde_pkg::div_cmd_type div_cmd;
   mde_pkg::div_sts_type div_sts;
   logic [DW-1:0]        div_dividend;
   logic [W-1:0]         div_divisor;
   logic [W-1:0]         div_rem;
   logic [W-1:0]         div_acc;

   logic                 req_fire;
   logic                 csr_write;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign csr_write = psel && penable && pwrite && pready;

   mde_div_unit #(
      .MODULUS_WIDTH (MODULUS_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .mult      (u_cur_ff),
      .sts       (div_sts),
      .remainder (div_rem),
      .acc       (div_acc)
   );

   always_comb begin
      state_in     = state_ff;
      mod_in       = mod_ff;
      b_in         = b_ff;
      a_red_in     = a_red_ff;
      r_prev_in    = r_prev_ff;
      r_cur_in     = r_cur_ff;
      u_prev_in    = u_prev_ff;
      u_cur_in     = u_cur_ff;
      neg_cur_in   = neg_cur_ff;
      inv_in       = inv_ff;
      prod_in      = prod_ff;
      quot_in      = quot_ff;
      flag_in      = flag_ff;
      div_cmd      = '0;
      div_dividend = '0;
      div_divisor  = mod_ff;

      if (csr_write && paddr[2] == mde_pkg::REG_MODULUS) begin
         mod_in = pwdata[W-1:0];
      end

      unique case (state_ff)
         mde_pkg::S_IDLE: begin
            div_dividend = DW'(req_ch.dividend);
            if (req_fire) begin
               b_in = req_ch.divisor;
               if (mod_ff == '0) begin
                  quot_in  = '0;
                  flag_in  = 1'b1;
                  state_in = mde_pkg::S_OUT;
               end else begin
                  div_cmd.start = 1'b1;
                  div_cmd.steps = STEPS_INPUT;
                  state_in      = mde_pkg::S_RED_A;
               end
            end
         end
         mde_pkg::S_RED_A: begin
            div_dividend = DW'(b_ff);
            if (div_sts.done) begin
               a_red_in      = div_rem;
               div_cmd.start = 1'b1;
               div_cmd.steps = STEPS_INPUT;
               state_in      = mde_pkg::S_RED_B;
            end
         end
         mde_pkg::S_RED_B: begin
            if (div_sts.done) begin
               r_prev_in  = mod_ff;
               r_cur_in   = div_rem;
               u_prev_in  = '0;
               u_cur_in   = (mod_ff == ONE) ? '0 : ONE;
               neg_cur_in = 1'b0;
               state_in   = mde_pkg::S_EUC_CHK;
            end
         end
         mde_pkg::S_EUC_CHK: begin
            div_dividend = DW'(r_prev_ff) << (DW - W);
            div_divisor  = r_cur_ff;
            if (r_cur_ff != '0) begin
               div_cmd.start = 1'b1;
               div_cmd.steps = STEPS_EUC;
               state_in      = mde_pkg::S_EUC_DIV;
            end else if (r_prev_ff != ONE) begin
               quot_in  = '0;
               flag_in  = 1'b1;
               state_in = mde_pkg::S_OUT;
            end else begin
               inv_in   = (!neg_cur_ff && u_prev_ff != '0) ? mod_ff - u_prev_ff : u_prev_ff;
               state_in = mde_pkg::S_MUL;
            end
         end
         mde_pkg::S_EUC_DIV: begin
            if (div_sts.done) begin
               r_prev_in  = r_cur_ff;
               r_cur_in   = div_rem;
               u_prev_in  = u_cur_ff;
               u_cur_in   = u_prev_ff + div_acc;
               neg_cur_in = !neg_cur_ff;
               state_in   = mde_pkg::S_EUC_CHK;
            end
         end
         mde_pkg::S_MUL: begin
            prod_in  = PW'(a_red_ff) * PW'(inv_ff);
            state_in = mde_pkg::S_PSTART;
         end
         mde_pkg::S_PSTART: begin
            div_dividend  = DW'(prod_ff) << (DW - PW);
            div_cmd.start = 1'b1;
            div_cmd.steps = STEPS_PROD;
            state_in      = mde_pkg::S_RED_P;
         end
         mde_pkg::S_RED_P: begin
            if (div_sts.done) begin
               quot_in  = div_rem;
               flag_in  = 1'b0;
               state_in = mde_pkg::S_OUT;
            end
         end
         mde_pkg::S_OUT: begin
            if (rsp_ch.ready) begin
               state_in = mde_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mde_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      b_ff       <= b_in;
      a_red_ff   <= a_red_in;
      r_prev_ff  <= r_prev_in;
      r_cur_ff   <= r_cur_in;
      u_prev_ff  <= u_prev_in;
      u_cur_ff   <= u_cur_in;
      neg_cur_ff <= neg_cur_in;
      inv_ff     <= inv_in;
      prod_ff    <= prod_in;
      quot_ff    <= quot_in;
      flag_ff    <= flag_in;
      if (reset) begin
         state_ff <= mde_pkg::S_IDLE;
         mod_ff   <= MOD_RESET;
      end else begin
         state_ff <= state_in;
         mod_ff   <= mod_in;
      end
   end

   assign req_ch.ready      = (state_ff == mde_pkg::S_IDLE);
   assign rsp_ch.valid      = (state_ff == mde_pkg::S_OUT);
   assign rsp_ch.quotient   = QW'(quot_ff);
   assign rsp_ch.no_inverse = flag_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == mde_pkg::REG_MODULUS) ? CW'(mod_ff) : '0;

`ifndef NO_ASSERTIONS
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.no_inverse |-> rsp_ch.quotient == '0)
      else $error("flagged response carries a nonzero quotient");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ch.ready)
      else $error("request accepted while a request is in progress");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready || rsp_ch.valid |-> !div_sts.busy && !div_sts.done)
      else $error("divider active outside of a request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(rsp_ch.quotient))
      else $error("response dropped or changed while stalled");
`endif

endmodule

// ===== test/modular_division_ext_euclid_tb.sv =====
// Self-checking testbench for modular_division_ext_euclid: modular quotients over several moduli.
// Drives requests and the modulus register, predicts every response, checks it field by field.
// Depends on mde_pkg, mde_req_if, mde_rsp_if and the block itself.
module modular_division_ext_euclid_tb;

   localparam int unsigned IW           = mde_pkg::INPUT_WIDTH;
   localparam int unsigned QW           = mde_pkg::QUOTIENT_WIDTH;
   localparam int unsigned AW           = mde_pkg::CSR_ADDR_WIDTH;
   localparam int unsigned CDW          = mde_pkg::CSR_DATA_WIDTH;
   localparam int unsigned CYCLE_LIMIT  = 4_000_000;
   localparam int unsigned DRAIN_CYCLES = 2000;
   localparam int unsigned HOLD_CYCLES  = 4000;
   localparam int unsigned MAX_GAP      = 4;
   localparam logic [AW-1:0] MODULUS_ADDR  = AW'(mde_pkg::REG_MODULUS) << 2;
   localparam logic [AW-1:0] UNMAPPED_ADDR = AW'(4);
   localparam logic [IW-1:0] OPERAND_MAX   = '1;

   typedef struct packed {
      logic [QW-1:0] quotient;
      logic          no_inverse;
   } division_result_type;

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [AW-1:0] paddr;
   logic [CDW-1:0] pwdata;
   logic [CDW-1:0] prdata;
   logic pready;

   mde_req_if req_ch();
   mde_rsp_if rsp_ch();

   division_result_type expected_quotients[$];
   logic [31:0] modulus_shadow = mde_pkg::MODULUS_RESET;
   int unsigned error_count = 0;
   int unsigned requests_sent = 0;
   int unsigned responses_seen = 0;
   int unsigned flagged_seen = 0;
   int unsigned modulus_settings = 1;
   int unsigned cycle_count = 0;
   int unsigned hold_off_cycles = 0;
   bit idle_enable = 1'b1;

   modular_division_ext_euclid dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic division_result_type predict_division(input logic [IW-1:0] dividend,
                                                            input logic [IW-1:0] divisor,
                                                            input logic [31:0] modulus);
      bit [63:0] m, a, b, r_prev, r_cur, t_prev, t_cur, q, r_next, qt, t_next;
      division_result_type res;
      res = '0;
      m = 64'(modulus);
      if (m == 0) begin
         res.no_inverse = 1'b1;
         return res;
      end
      a = 64'(dividend) % m;
      b = 64'(divisor) % m;
      r_prev = m;
      r_cur = b;
      t_prev = 0;
      t_cur = (m == 1) ? 64'd0 : 64'd1;
      while (r_cur != 0) begin
         q = r_prev / r_cur;
         r_next = r_prev - q * r_cur;
         qt = (q * t_cur) % m;
         t_next = (t_prev + m - qt) % m;
         r_prev = r_cur;
         r_cur = r_next;
         t_prev = t_cur;
         t_cur = t_next;
      end
      if (r_prev != 1) begin
         res.no_inverse = 1'b1;
         return res;
      end
      res.quotient = QW'((a * t_prev) % m);
      return res;
   endfunction

   function automatic logic [IW-1:0] random_operand(input logic [31:0] modulus);
      bit [63:0] m, v;
      m = 64'(modulus);
      case ($urandom_range(0, 5))
         0: v = {$urandom, $urandom};
         1: v = 64'($urandom_range(0, 20));
         2: v = m * 64'($urandom);
         3: v = m * 64'($urandom_range(0, 1000)) + 64'($urandom_range(0, 3));
         4: v = 64'(OPERAND_MAX) - 64'($urandom_range(0, 3));
         default: v = (m == 0) ? 64'($urandom) : {$urandom, $urandom} % m;
      endcase
      return v[IW-1:0];
   endfunction

   function automatic int unsigned draw_gap();
      return idle_enable ? $urandom_range(0, MAX_GAP) : 0;
   endfunction

   task automatic send_request(input logic [IW-1:0] dividend,
                               input logic [IW-1:0] divisor);
      int unsigned gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.dividend <= dividend;
      req_ch.divisor  <= divisor;
      do @(posedge clock); while (!req_ch.ready);
      expected_quotients.insert(expected_quotients.size(),
                                predict_division(dividend, divisor, modulus_shadow));
      requests_sent++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_quotients.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [AW-1:0] addr, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == MODULUS_ADDR) modulus_shadow = value;
   endtask

   task automatic check_modulus_readback();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= MODULUS_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== modulus_shadow) begin
         $error("modulus: expected %0d, actual %0d", modulus_shadow, prdata);
         error_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_modulus(input logic [31:0] value);
      wait_drained();
      write_csr(MODULUS_ADDR, value);
      @(posedge clock);
      check_modulus_readback();
      @(posedge clock);
      modulus_settings++;
   endtask

   // drain responses with random stalls; a requested hold-off replaces one stall
   initial begin : response_drain
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = draw_gap();
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   always @(posedge clock) begin
      division_result_type exp_res;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         responses_seen++;
         if (rsp_ch.no_inverse === 1'b1) flagged_seen++;
         if (expected_quotients.size() == 0) begin
            $error("response with no request outstanding: quotient %0d, no_inverse %0d",
                   rsp_ch.quotient, rsp_ch.no_inverse);
            error_count++;
         end else begin
            exp_res = expected_quotients.pop_front();
            if (rsp_ch.quotient !== exp_res.quotient) begin
               $error("quotient: expected %0d, actual %0d", exp_res.quotient, rsp_ch.quotient);
               error_count++;
            end
            if (rsp_ch.no_inverse !== exp_res.no_inverse) begin
               $error("no_inverse: expected %0d, actual %0d",
                      exp_res.no_inverse, rsp_ch.no_inverse);
               error_count++;
            end
         end
      end
   end

   task automatic test_reset_modulus();
      check_modulus_readback();
      @(posedge clock);
      send_request(1, 1);
      send_request(0, 5);
      send_request(OPERAND_MAX, OPERAND_MAX);
      send_request(OPERAND_MAX, 0);
      send_request(5, IW'(mde_pkg::MODULUS_RESET));
      send_request(1, 2);
   endtask

   task automatic test_field_extremes();
      send_request(0, OPERAND_MAX);
      send_request(OPERAND_MAX, 1);
      send_request(63'h2AAA_AAAA_AAAA_AAAA, 63'h4000_0000_0000_0000);
      send_request(63'h5555_5555_5555_5555, 63'h1555_5555_5555_5555);
   endtask

   task automatic test_shared_factor();
      set_modulus(12);
      send_request(7, 6);
      send_request(7, 5);
      send_request(7, 0);
   endtask

   task automatic test_modulus_extremes();
      set_modulus(2);
      send_request(OPERAND_MAX, 3);
      set_modulus(32'hFFFF_FFFF);
      send_request(OPERAND_MAX, 3);
      send_request(OPERAND_MAX, 2);
      set_modulus(0);
      send_request(5, 3);
      set_modulus(1);
      send_request(7, 0);
      send_request(7, 3);
   endtask

   task automatic test_unmapped_address();
      wait_drained();
      write_csr(UNMAPPED_ADDR, 32'd97);
      @(posedge clock);
      check_modulus_readback();
      @(posedge clock);
      send_request(10, 4);
   endtask

   task automatic test_backpressure();
      set_modulus(mde_pkg::MODULUS_RESET);
      hold_off_cycles = HOLD_CYCLES;
      repeat (6) send_request(random_operand(modulus_shadow), random_operand(modulus_shadow));
      wait_drained();
      repeat (6) send_request(random_operand(modulus_shadow), random_operand(modulus_shadow));
   endtask

   task automatic test_random_moduli();
      logic [31:0] modulus;
      int unsigned count;
      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0: begin modulus = mde_pkg::MODULUS_RESET; count = 100; end
            1: begin modulus = $urandom; count = 60; end
            2: begin modulus = $urandom; count = 60; end
            3: begin modulus = 32'hFFFF_FFFF; count = 60; end
            4: begin modulus = 32'h8000_0000; count = 50; end
            5: begin modulus = $urandom_range(2, 64); count = 50; end
            6: begin modulus = 2; count = 20; end
            7: begin modulus = $urandom_range(32'h1_0000, 32'hF_FFFF); count = 50; end
            8: begin modulus = 1; count = 15; end
            9: begin modulus = 0; count = 15; end
            10: begin modulus = $urandom; count = 80; end
            default: begin modulus = 3; count = 20; end
         endcase
         if (modulus < 2 && phase < 8) modulus = 2;
         set_modulus(modulus);
         idle_enable = (phase != 2);
         repeat (count) begin
            if ($urandom_range(0, 9) == 0)
               send_request(($urandom_range(0, 1) != 0) ? OPERAND_MAX : '0,
                            random_operand(modulus_shadow));
            else
               send_request(IW'({$urandom, $urandom}), random_operand(modulus_shadow));
         end
         idle_enable = 1'b1;
      end
   endtask

   initial begin : run
      reset          <= 1'b1;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.dividend <= '0;
      req_ch.divisor  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_modulus();
      test_field_extremes();
      test_shared_factor();
      test_modulus_extremes();
      test_unmapped_address();
      test_backpressure();
      test_random_moduli();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests and %0d responses over %0d modulus settings",
               requests_sent, responses_seen, modulus_settings);
      $display("%0d responses flagged a missing inverse", flagged_seen);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
